// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

    // defaults for the top-level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;

    // fixed field widths
    localparam int DATA_W  = 32;
    localparam int IPRIO_W = 8;
    localparam int COUNT_W = 5;

    // operation codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_spq_status;

    // input word
    typedef struct packed {
        logic                       mode;
        logic signed [DATA_W-1:0]   in_data;
        logic        [IPRIO_W-1:0]  in_priority;
    } t_spq_in;

    // result word
    typedef struct packed {
        logic signed [DATA_W-1:0]   out_data;
        t_spq_status                status;
        logic                       is_empty;
        logic        [COUNT_W-1:0]  entry_count;
    } t_spq_out;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_spq_ctrl;

endpackage

// ----- hw/rtl/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell #(
    parameter int PRIORITY_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  logic                              i_clk,
    input  spq_pkg::t_spq_ctrl                i_ctrl,
    input  logic                              i_occupied,
    input  logic [spq_pkg::DATA_W-1:0]        i_new_data,
    input  logic [PRIORITY_BITS-1:0]          i_new_prio,
    input  logic                              i_left_behind,
    input  logic [spq_pkg::DATA_W-1:0]        i_left_data,
    input  logic [PRIORITY_BITS-1:0]          i_left_prio,
    input  logic [spq_pkg::DATA_W-1:0]        i_right_data,
    input  logic [PRIORITY_BITS-1:0]          i_right_prio,
    output logic                              o_behind,
    output logic [spq_pkg::DATA_W-1:0]        o_data,
    output logic [PRIORITY_BITS-1:0]          o_prio
);
    import spq_pkg::*;

    logic [DATA_W-1:0]        r_data, n_data;
    logic [PRIORITY_BITS-1:0] r_prio, n_prio;

    // held entry stays ahead of a new one of equal or higher priority number
    assign o_behind = i_occupied && (r_prio <= i_new_prio);

    // keep, take the new word, shift in from the left, or shift in from the right
    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctrl.enq) begin
            if (!o_behind) begin
                if (i_left_behind) begin
                    n_data = i_new_data;
                    n_prio = i_new_prio;
                end else begin
                    n_data = i_left_data;
                    n_prio = i_left_prio;
                end
            end
        end else if (i_ctrl.deq) begin
            n_data = i_right_data;
            n_prio = i_right_prio;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data = r_data;
    assign o_prio = r_prio;

endmodule

// ----- hw/rtl/sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps

// Sorted priority queue built as a row of cells, cell 0 holding the front entry.
// Input channel: drive i_word (mode, in_data, in_priority) and raise i_start; the
// word is taken at a rising edge with i_start high and o_busy low. o_busy stays
// low, so a new word may be given in every cycle.
// Result channel: one result per word, shown on o_word for exactly one cycle with
// o_valid high, in the cycle after the word was taken.
// Throughput is one word per cycle: every cell compares its priority with the
// broadcast one and loads from itself, the new word or a neighbor.
// Enqueue places the word behind all entries of equal or lower priority number;
// dequeue returns the front entry's data. Dequeue on empty gives status empty
// and data zero; enqueue on full is dropped with status full.
// The receiver cannot stall: a result not taken in its cycle is gone.
// Reset (synchronous, active low) empties the queue at once; slot contents are
// not cleared since slots beyond the count are never read.
module sorted_priority_queue_top #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  spq_pkg::t_spq_in  i_word,
    output logic              o_busy,
    output logic              o_valid,
    output spq_pkg::t_spq_out o_word
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]            r_count, n_count;
    logic                     r_valid;
    t_spq_out                 r_word, n_word;

    logic                     w_take;
    logic                     w_full;
    logic                     w_empty;
    t_spq_ctrl                w_ctrl;
    logic [PRIORITY_BITS-1:0] w_new_prio;

    logic [DATA_W-1:0]        w_data   [DEPTH];
    logic [PRIORITY_BITS-1:0] w_prio   [DEPTH];
    logic                     w_behind [DEPTH];

    assign o_busy     = 1'b0;
    assign w_take     = i_start && !o_busy;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_new_prio = PRIORITY_BITS'(i_word.in_priority);

    // command to the cells
    assign w_ctrl.enq = w_take && (i_word.mode == MODE_ENQ) && !w_full;
    assign w_ctrl.deq = w_take && (i_word.mode == MODE_DEQ) && !w_empty;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                     w_lb;
        logic [DATA_W-1:0]        w_ld, w_rd;
        logic [PRIORITY_BITS-1:0] w_lp, w_rp;

        if (g == 0) begin : g_first
            assign w_lb = 1'b1;
            assign w_ld = i_word.in_data;
            assign w_lp = w_new_prio;
        end else begin : g_mid
            assign w_lb = w_behind[g-1];
            assign w_ld = w_data[g-1];
            assign w_lp = w_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rd = w_data[g];
            assign w_rp = w_prio[g];
        end else begin : g_inner
            assign w_rd = w_data[g+1];
            assign w_rp = w_prio[g+1];
        end

        spq_cell #(
            .PRIORITY_BITS(PRIORITY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (CW'(g) < r_count),
            .i_new_data   (i_word.in_data),
            .i_new_prio   (w_new_prio),
            .i_left_behind(w_lb),
            .i_left_data  (w_ld),
            .i_left_prio  (w_lp),
            .i_right_data (w_rd),
            .i_right_prio (w_rp),
            .o_behind     (w_behind[g]),
            .o_data       (w_data[g]),
            .o_prio       (w_prio[g])
        );
    end

    // next count and result word
    always_comb begin
        n_count = r_count;
        n_word.out_data = '0;
        n_word.status   = ST_DONE;
        if (w_take) begin
            if (i_word.mode == MODE_ENQ) begin
                if (w_full) begin
                    n_word.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (w_empty) begin
                    n_word.status = ST_EMPTY;
                end else begin
                    n_word.out_data = w_data[0];
                    n_count = r_count - CW'(1);
                end
            end
        end
        n_word.is_empty    = (n_count == '0);
        n_word.entry_count = COUNT_W'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_take;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
